>>> hw/rtl/g2r_pkg.sv
// Package for the two-bit-per-pixel glyph rasterizer.
// Holds field widths, register indexes and the word types shared by all modules.
// No dependencies.
package g2r_pkg;

	localparam int ADDR_BITS     = 20;
	localparam int PIX_ADDR_W    = 20;
	localparam int BYTE_W        = 8;
	localparam int ORG_X_W       = 12;
	localparam int ORG_Y_W       = 11;
	localparam int PITCH_W       = 12;
	localparam int COLOR_W       = 8;
	localparam int BIR_W         = 6;
	localparam int PIX_PER_BYTE  = 4;
	localparam int SLOT_IDX_W    = 2;
	localparam int SLOT_CNT_W    = 3;
	localparam int BASE_W        = ORG_Y_W + PITCH_W + 1;

	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MAIN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_SHADOW = 2'd2;

	localparam logic [PITCH_W-1:0] PITCH_RESET = 12'd640;

	localparam logic [1:0] CODE_CLEAR = 2'd0;

	typedef logic [ADDR_BITS-1:0] addr_t;

	typedef struct packed {
		logic [PITCH_W-1:0] line_pitch;
		logic [COLOR_W-1:0] color_main;
		logic [COLOR_W-1:0] color_shadow;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  record_byte;
		logic               start_of_glyph;
		logic [ORG_X_W-1:0] origin_x;
		logic [ORG_Y_W-1:0] origin_y;
	} in_word_t;

	typedef struct packed {
		logic                  write_enable;
		logic [PIX_ADDR_W-1:0] pixel_address;
		logic [COLOR_W-1:0]    pixel_value;
		logic [BYTE_W-1:0]     advance_width;
		logic                  glyph_done;
	} out_word_t;

	typedef struct packed {
		logic [SLOT_CNT_W-1:0]           count;
		out_word_t [PIX_PER_BYTE-1:0]    slot;
	} result_set_t;

endpackage

>>> hw/rtl/g2r_glyph_if.sv
// Input channel of the glyph rasterizer: one glyph record byte per word.
// Depends on g2r_pkg for the field widths.
interface g2r_glyph_if;
	logic                           valid;
	logic                           ready;
	logic [g2r_pkg::BYTE_W-1:0]     record_byte;
	logic                           start_of_glyph;
	logic [g2r_pkg::ORG_X_W-1:0]    origin_x;
	logic [g2r_pkg::ORG_Y_W-1:0]    origin_y;

	modport source(output valid, record_byte, start_of_glyph, origin_x, origin_y,
		input ready);
	modport sink(input valid, record_byte, start_of_glyph, origin_x, origin_y,
		output ready);
endinterface

>>> hw/rtl/g2r_pixel_if.sv
// Output channel of the glyph rasterizer: one frame-buffer write or end marker per word.
// Depends on g2r_pkg for the field widths.
interface g2r_pixel_if;
	logic                             valid;
	logic                             ready;
	logic                             write_enable;
	logic [g2r_pkg::PIX_ADDR_W-1:0]   pixel_address;
	logic [g2r_pkg::COLOR_W-1:0]      pixel_value;
	logic [g2r_pkg::BYTE_W-1:0]       advance_width;
	logic                             glyph_done;

	modport source(output valid, write_enable, pixel_address, pixel_value,
		advance_width, glyph_done, input ready);
	modport sink(input valid, write_enable, pixel_address, pixel_value,
		advance_width, glyph_done, output ready);
endinterface

>>> hw/rtl/g2r_cfg_regs.sv
// Configuration registers of the glyph rasterizer: line pitch and the two colors.
// Depends on g2r_pkg.
module g2r_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [g2r_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [g2r_pkg::CFG_DATA_W-1:0]   cfg_data,
	output g2r_pkg::cfg_t                    cfg
);

	g2r_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_pitch   <= g2r_pkg::PITCH_RESET;
			cfg_q.color_main   <= '0;
			cfg_q.color_shadow <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				g2r_pkg::CFG_LINE_PITCH: begin
					cfg_q.line_pitch <= cfg_data[g2r_pkg::PITCH_W-1:0];
				end
				g2r_pkg::CFG_COLOR_MAIN: begin
					cfg_q.color_main <= cfg_data[g2r_pkg::COLOR_W-1:0];
				end
				g2r_pkg::CFG_COLOR_SHADOW: begin
					cfg_q.color_shadow <= cfg_data[g2r_pkg::COLOR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/g2r_decode.sv
// Record parser and pixel decoder: holds the glyph state and turns one record byte
// into up to four packed result words. Depends on g2r_pkg.
module g2r_decode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  g2r_pkg::in_word_t     word,
	input  g2r_pkg::cfg_t         cfg,
	output g2r_pkg::result_set_t  res
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEIGHT,
		PH_WIDTH,
		PH_DATA
	} phase_t;

	phase_t                                phase_q, phase_d;
	logic [g2r_pkg::BYTE_W-1:0]            height_q, height_d;
	logic [g2r_pkg::BYTE_W-1:0]            width_q, width_d;
	logic [g2r_pkg::BYTE_W-1:0]            rows_left_q, rows_left_d;
	logic [g2r_pkg::BIR_W-1:0]             bir_q, bir_d;
	g2r_pkg::addr_t                        base_q, base_d;

	logic [g2r_pkg::BASE_W-1:0]            start_base;
	logic [g2r_pkg::BASE_W+g2r_pkg::ADDR_BITS-1:0] start_ext;
	logic [g2r_pkg::BIR_W-1:0]             bir_inc;
	logic [g2r_pkg::BIR_W-1:0]             words_per_row;
	logic [g2r_pkg::BIR_W:0]               row_bytes;
	logic                                  row_end;
	logic [g2r_pkg::BYTE_W-1:0]            rows_dec;
	logic [1:0]                            code;
	logic [g2r_pkg::BYTE_W-1:0]            col;
	g2r_pkg::addr_t                        pix_addr;
	logic [g2r_pkg::ADDR_BITS+g2r_pkg::PIX_ADDR_W-1:0] addr_ext;
	logic [g2r_pkg::SLOT_CNT_W-1:0]        pos;
	logic [g2r_pkg::SLOT_IDX_W-1:0]        last_idx;

	assign start_base = g2r_pkg::BASE_W'(word.origin_y) * g2r_pkg::BASE_W'(cfg.line_pitch)
		+ g2r_pkg::BASE_W'(word.origin_x);
	assign start_ext  = {{g2r_pkg::ADDR_BITS{1'b0}}, start_base};

	assign bir_inc       = bir_q + 1'b1;
	assign words_per_row = g2r_pkg::BIR_W'(({1'b0, width_q} + 9'd7) >> 3);
	assign row_bytes     = {words_per_row, 1'b0};
	assign row_end       = ({1'b0, bir_inc} >= row_bytes) || (bir_inc == '0);
	assign rows_dec      = rows_left_q - 1'b1;

	always_comb begin
		phase_d     = phase_q;
		height_d    = height_q;
		width_d     = width_q;
		rows_left_d = rows_left_q;
		bir_d       = bir_q;
		base_d      = base_q;
		res         = '0;
		pos         = '0;
		code        = '0;
		col         = '0;
		pix_addr    = '0;
		addr_ext    = '0;
		last_idx    = '0;

		if (word.start_of_glyph) begin
			base_d      = start_ext[g2r_pkg::ADDR_BITS-1:0];
			height_d    = '0;
			width_d     = '0;
			rows_left_d = '0;
			bir_d       = '0;
			phase_d     = PH_HEIGHT;
		end else begin
			case (phase_q)
				PH_HEIGHT: begin
					height_d    = word.record_byte;
					rows_left_d = word.record_byte;
					phase_d     = PH_WIDTH;
				end
				PH_WIDTH: begin
					width_d = word.record_byte;
					bir_d   = '0;
					if (height_q == '0 || word.record_byte == '0) begin
						res.count                 = 3'd1;
						res.slot[0].advance_width = word.record_byte;
						res.slot[0].glyph_done    = 1'b1;
						phase_d                   = PH_IDLE;
					end else begin
						phase_d = PH_DATA;
					end
				end
				PH_DATA: begin
					for (int j = 0; j < g2r_pkg::PIX_PER_BYTE; j++) begin
						code     = word.record_byte[7-2*j -: 2];
						col      = {bir_q, 2'(j)};
						pix_addr = base_q + g2r_pkg::ADDR_BITS'(col);
						addr_ext = {{g2r_pkg::PIX_ADDR_W{1'b0}}, pix_addr};
						if (code != g2r_pkg::CODE_CLEAR && col < width_q) begin
							res.slot[pos[g2r_pkg::SLOT_IDX_W-1:0]].write_enable  = 1'b1;
							res.slot[pos[g2r_pkg::SLOT_IDX_W-1:0]].pixel_address =
								addr_ext[g2r_pkg::PIX_ADDR_W-1:0];
							res.slot[pos[g2r_pkg::SLOT_IDX_W-1:0]].pixel_value   =
								code[1] ? cfg.color_shadow : cfg.color_main;
							pos = pos + 1'b1;
						end
					end
					res.count = pos;
					bir_d     = bir_inc;
					if (row_end) begin
						bir_d       = '0;
						base_d      = base_q + g2r_pkg::ADDR_BITS'(cfg.line_pitch);
						rows_left_d = rows_dec;
						if (rows_dec == '0) begin
							phase_d = PH_IDLE;
							if (pos != '0) begin
								last_idx = g2r_pkg::SLOT_IDX_W'(pos - 1'b1);
								res.slot[last_idx].advance_width = width_q;
								res.slot[last_idx].glyph_done    = 1'b1;
							end else begin
								res.count                 = 3'd1;
								res.slot[0].advance_width = width_q;
								res.slot[0].glyph_done    = 1'b1;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			height_q    <= '0;
			width_q     <= '0;
			rows_left_q <= '0;
			bir_q       <= '0;
			base_q      <= '0;
		end else if (take) begin
			phase_q     <= phase_d;
			height_q    <= height_d;
			width_q     <= width_d;
			rows_left_q <= rows_left_d;
			bir_q       <= bir_d;
			base_q      <= base_d;
		end
	end

endmodule

>>> hw/rtl/g2r_result_q.sv
// Result buffer: holds the up to four words of one record byte and sends them
// out one per cycle while pop is high, head first. Depends on g2r_pkg.
module g2r_result_q (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  g2r_pkg::result_set_t  res,
	input  logic                  pop,
	output logic                  free,
	output logic                  head_valid,
	output g2r_pkg::out_word_t    head
);

	g2r_pkg::out_word_t              slot_q [g2r_pkg::PIX_PER_BYTE];
	logic [g2r_pkg::SLOT_CNT_W-1:0]  cnt_q;

	assign head_valid = (cnt_q != '0);
	assign head       = slot_q[0];
	assign free       = (cnt_q == '0) || (cnt_q == 3'd1 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= res.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < g2r_pkg::PIX_PER_BYTE; k++) begin
				slot_q[k] <= res.slot[k];
			end
		end else if (pop) begin
			for (int k = 0; k < g2r_pkg::PIX_PER_BYTE - 1; k++) begin
				slot_q[k] <= slot_q[k+1];
			end
		end
	end

endmodule

>>> hw/rtl/glyph_2bpp_rasterizer.sv
// Top level of the two-bit-per-pixel glyph rasterizer.
// Depends on g2r_pkg, g2r_glyph_if, g2r_pixel_if, g2r_cfg_regs, g2r_decode, g2r_result_q.
//
//   channel   direction  word
//   glyph     in         one record byte with start flag and glyph origin
//   pixels    out        one frame-buffer write, or an end marker
//   cfg_*     in         register write: line pitch, main color, shadow color
//
// A record byte is registered on entry, then decoded and loaded into the result buffer
// once it is free, and its first result leaves from the buffer register.
// A byte with several results, at most four, holds the input until the single output
// port sends the last; bytes with no or one result pass at one per cycle unless it stalls.
// Reset clears the glyph state, the buffers and the registers to their defaults.
// Stalls on the output back up through the result buffer into the input register.
module glyph_2bpp_rasterizer (
	input  logic                             clk,
	input  logic                             arst_n,
	g2r_glyph_if.sink                        glyph,
	g2r_pixel_if.source                      pixels,
	input  logic                             cfg_we,
	input  logic [g2r_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [g2r_pkg::CFG_DATA_W-1:0]   cfg_data
);

	g2r_pkg::cfg_t         cfg;
	g2r_pkg::in_word_t     word_s1;
	logic                  valid_s1;
	logic                  take;
	logic                  free;
	logic                  pop;
	logic                  head_valid;
	g2r_pkg::out_word_t    head;
	g2r_pkg::result_set_t  res;

	assign take        = valid_s1 && free;
	assign glyph.ready = !valid_s1 || take;
	assign pop         = head_valid && pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (glyph.ready) begin
			valid_s1 <= glyph.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (glyph.valid && glyph.ready) begin
			word_s1.record_byte    <= glyph.record_byte;
			word_s1.start_of_glyph <= glyph.start_of_glyph;
			word_s1.origin_x       <= glyph.origin_x;
			word_s1.origin_y       <= glyph.origin_y;
		end
	end

	g2r_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	g2r_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.word   (word_s1),
		.cfg    (cfg),
		.res    (res)
	);

	g2r_result_q u_result_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (take),
		.res        (res),
		.pop        (pop),
		.free       (free),
		.head_valid (head_valid),
		.head       (head)
	);

	assign pixels.valid         = head_valid;
	assign pixels.write_enable  = head.write_enable;
	assign pixels.pixel_address = head.pixel_address;
	assign pixels.pixel_value   = head.pixel_value;
	assign pixels.advance_width = head.advance_width;
	assign pixels.glyph_done    = head.glyph_done;

endmodule
